[hw/rtl/ebr_pkg.sv]
// Shared types for the ellipse rasteriser: item operation codes and stage control.
`timescale 1ns / 1ps

package ebr_pkg;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Control word handed from the input register to the walk stage
    typedef struct packed
    {
        logic valid;
        op_t  op;
    } stage_ctl_t;

endpackage

[hw/rtl/ebr_input_stage.sv]
// Input register of the ellipse rasteriser, with the squares of both semi-axes.
`timescale 1ns / 1ps

module ebr_input_stage
    import ebr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int AXIS_BITS  = 11,
    parameter int SQW        = 2 * AXIS_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  op,
    input  logic [COORD_BITS-1:0] center_x,
    input  logic [COORD_BITS-1:0] center_y,
    input  logic [AXIS_BITS-1:0]  semi_axis_a,
    input  logic [AXIS_BITS-1:0]  semi_axis_b,
    input  logic                  advance,
    output stage_ctl_t            ctl,
    output logic [COORD_BITS-1:0] cx,
    output logic [COORD_BITS-1:0] cy,
    output logic [AXIS_BITS-1:0]  b,
    output logic [SQW-1:0]        aa,
    output logic [SQW-1:0]        bb
);

    stage_ctl_t            ctl_reg;
    stage_ctl_t            ctl_next;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [AXIS_BITS-1:0]  b_reg;
    logic [SQW-1:0]        aa_reg;
    logic [SQW-1:0]        bb_reg;
    logic                  load;

    // Hold the item while the walk stage cannot take it
    assign item_stall = ctl_reg.valid && !advance;
    assign load       = item_valid && !item_stall;

    always_comb
    begin
        ctl_next = ctl_reg;
        if (load)
        begin
            ctl_next.valid = 1'b1;
            ctl_next.op    = op_t'(op);
        end
        else if (advance)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, op: OP_START};
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            b_reg  <= semi_axis_b;
            aa_reg <= SQW'(semi_axis_a) * SQW'(semi_axis_a);
            bb_reg <= SQW'(semi_axis_b) * SQW'(semi_axis_b);
        end
    end

    assign ctl = ctl_reg;
    assign cx  = cx_reg;
    assign cy  = cy_reg;
    assign b   = b_reg;
    assign aa  = aa_reg;
    assign bb  = bb_reg;

    property p_stall_needs_item;
        @(posedge clk) disable iff (!rst_n)
        item_stall |-> ctl_reg.valid;
    endproperty
    a_stall_needs_item: assert property (p_stall_needs_item)
        else $error("input stall raised with an empty input register");

    property p_load_fills;
        @(posedge clk) disable iff (!rst_n)
        load |=> ctl_reg.valid;
    endproperty
    a_load_fills: assert property (p_load_fills)
        else $error("accepted transaction did not fill the input register");

    property p_drain_empties;
        @(posedge clk) disable iff (!rst_n)
        advance && !load |=> !ctl_reg.valid;
    endproperty
    a_drain_empties: assert property (p_drain_empties)
        else $error("input register still full after its item moved on");

endmodule

[hw/rtl/ebr_walk.sv]
// One move of the error-term walk, using running products 2*b^2*x and 2*a^2*y.
`timescale 1ns / 1ps

module ebr_walk
#(
    parameter int AXIS_BITS = 11,
    parameter int XW        = AXIS_BITS + 2,
    parameter int SQW       = 2 * AXIS_BITS,
    parameter int DW        = 3 * AXIS_BITS + 5
)
(
    input  logic [XW-1:0]         x,
    input  logic [XW-1:0]         y,
    input  logic signed [DW-1:0]  d,
    input  logic signed [DW-1:0]  px,
    input  logic signed [DW-1:0]  py,
    input  logic [SQW-1:0]        aa,
    input  logic [SQW-1:0]        bb,
    output logic [XW-1:0]         x_next,
    output logic [XW-1:0]         y_next,
    output logic signed [DW-1:0]  d_next,
    output logic signed [DW-1:0]  px_next,
    output logic signed [DW-1:0]  py_next
);

    logic signed [DW-1:0] aa_s;
    logic signed [DW-1:0] bb_s;
    logic signed [DW-1:0] d2;
    logic signed [DW-1:0] t_h;
    logic signed [DW-1:0] t_v;
    logic signed [DW-1:0] dx_term;
    logic signed [DW-1:0] dy_term;
    logic                 d_neg;
    logic                 d_pos;
    logic                 t_v_pos;
    logic                 move_x;
    logic                 move_y;

    assign aa_s  = $signed(DW'(aa));
    assign bb_s  = $signed(DW'(bb));
    assign d2    = d + d;

    // Horizontal/diagonal test below the curve, vertical/diagonal test above it
    assign t_h   = d2 + py - aa_s;
    assign t_v   = d2 - px - bb_s;

    assign d_neg   = d[DW-1];
    assign d_pos   = !d_neg && (d != '0);
    assign t_v_pos = !t_v[DW-1] && (t_v != '0);

    assign move_x = !d_pos || !t_v_pos;
    assign move_y = !d_neg || !t_h[DW-1];

    assign x_next  = move_x ? x + XW'(1) : x;
    assign y_next  = move_y ? y - XW'(1) : y;
    assign px_next = move_x ? px + bb_s + bb_s : px;
    assign py_next = move_y ? py - aa_s - aa_s : py;

    assign dx_term = move_x ? px_next + bb_s : '0;
    assign dy_term = move_y ? aa_s - py_next : '0;
    assign d_next  = d + dx_term + dy_term;

endmodule

[hw/rtl/ellipse_bresenham_rasterizer.sv]
// Top level of the ellipse rasteriser: walk state, result register and flow control.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_stall      op, center_x, center_y,
//                                                    semi_axis_a, semi_axis_b
//  result    out        result_valid / result_stall  valid_res, right_x, left_x,
//                                                    upper_y, lower_y, last
//
// One transaction in and one out per clock when the result side does not stall.
// An item passes two registers: the input register (squares of the semi-axes) and the
// result register (walk move, or the a^2*b product of a start, into the state).
// rst_n clears the register valids and drops any ellipse in progress.
// A stalled result holds; the input register still takes one transaction while
// the result waits, then item_stall rises until the result is taken.
`timescale 1ns / 1ps

module ellipse_bresenham_rasterizer
    import ebr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int AXIS_BITS  = 11
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         op,
    input  logic [COORD_BITS-1:0]        center_x,
    input  logic [COORD_BITS-1:0]        center_y,
    input  logic [AXIS_BITS-1:0]         semi_axis_a,
    input  logic [AXIS_BITS-1:0]         semi_axis_b,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         valid_res,
    output logic signed [COORD_BITS+1:0] right_x,
    output logic signed [COORD_BITS+1:0] left_x,
    output logic signed [COORD_BITS+1:0] upper_y,
    output logic signed [COORD_BITS+1:0] lower_y,
    output logic                         last
);

    localparam int OUTW = COORD_BITS + 2;
    localparam int XW   = AXIS_BITS + 2;
    localparam int SQW  = 2 * AXIS_BITS;
    localparam int PW   = SQW + AXIS_BITS;
    localparam int DW   = 3 * AXIS_BITS + 5;
    localparam int SUMW = (OUTW > XW) ? OUTW : XW;

    // Input register outputs
    stage_ctl_t            a_ctl;
    logic [COORD_BITS-1:0] a_cx;
    logic [COORD_BITS-1:0] a_cy;
    logic [AXIS_BITS-1:0]  a_b;
    logic [SQW-1:0]        a_aa;
    logic [SQW-1:0]        a_bb;
    logic                  advance;

    // Walk state
    logic                  active_reg;
    logic                  active_next;
    logic [XW-1:0]         x_reg;
    logic [XW-1:0]         x_next;
    logic [XW-1:0]         y_reg;
    logic [XW-1:0]         y_next;
    logic signed [DW-1:0]  d_reg;
    logic signed [DW-1:0]  d_next;
    logic signed [DW-1:0]  px_reg;
    logic signed [DW-1:0]  px_next;
    logic signed [DW-1:0]  py_reg;
    logic signed [DW-1:0]  py_next;
    logic [SQW-1:0]        aa_reg;
    logic [SQW-1:0]        aa_next;
    logic [SQW-1:0]        bb_reg;
    logic [SQW-1:0]        bb_next;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cx_next;
    logic [COORD_BITS-1:0] cy_reg;
    logic [COORD_BITS-1:0] cy_next;

    // Walk unit results
    logic [XW-1:0]         w_x;
    logic [XW-1:0]         w_y;
    logic signed [DW-1:0]  w_d;
    logic signed [DW-1:0]  w_px;
    logic signed [DW-1:0]  w_py;

    // Start values
    logic [PW-1:0]         aab;
    logic signed [DW-1:0]  py_start;
    logic signed [DW-1:0]  d_start;

    // Result register
    logic                  result_valid_reg;
    logic                  result_valid_next;
    logic                  valid_res_reg;
    logic                  valid_res_next;
    logic                  last_reg;
    logic                  last_next;
    logic signed [OUTW-1:0] right_x_reg;
    logic signed [OUTW-1:0] right_x_next;
    logic signed [OUTW-1:0] left_x_reg;
    logic signed [OUTW-1:0] left_x_next;
    logic signed [OUTW-1:0] upper_y_reg;
    logic signed [OUTW-1:0] upper_y_next;
    logic signed [OUTW-1:0] lower_y_reg;
    logic signed [OUTW-1:0] lower_y_next;

    // Point assembly
    logic                  is_start;
    logic                  emit;
    logic [COORD_BITS-1:0] cx_sel;
    logic [COORD_BITS-1:0] cy_sel;
    logic [XW-1:0]         x_sel;
    logic [XW-1:0]         y_sel;
    logic [SUMW-1:0]       rx_sum;
    logic [SUMW-1:0]       lx_sum;
    logic [SUMW-1:0]       uy_sum;
    logic [SUMW-1:0]       ly_sum;

    ebr_input_stage #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS),
        .SQW        (SQW)
    ) u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .op          (op),
        .center_x    (center_x),
        .center_y    (center_y),
        .semi_axis_a (semi_axis_a),
        .semi_axis_b (semi_axis_b),
        .advance     (advance),
        .ctl         (a_ctl),
        .cx          (a_cx),
        .cy          (a_cy),
        .b           (a_b),
        .aa          (a_aa),
        .bb          (a_bb)
    );

    ebr_walk #(
        .AXIS_BITS (AXIS_BITS),
        .XW        (XW),
        .SQW       (SQW),
        .DW        (DW)
    ) u_walk (
        .x       (x_reg),
        .y       (y_reg),
        .d       (d_reg),
        .px      (px_reg),
        .py      (py_reg),
        .aa      (aa_reg),
        .bb      (bb_reg),
        .x_next  (w_x),
        .y_next  (w_y),
        .d_next  (w_d),
        .px_next (w_px),
        .py_next (w_py)
    );

    // Move the held item on whenever the result register is free or being drained
    assign advance = a_ctl.valid && (!result_valid_reg || !result_stall);

    // Start: y = b, so 2*a^2*y = 2*a^2*b and d = a^2 + b^2 - 2*a^2*b
    assign aab      = PW'(a_aa) * PW'(a_b);
    assign py_start = $signed(DW'({aab, 1'b0}));
    assign d_start  = $signed(DW'(a_aa)) + $signed(DW'(a_bb)) - py_start;

    assign is_start = (a_ctl.op == OP_START);
    assign emit     = is_start || active_reg;

    // Pick the centre and offsets of the point set to emit
    assign cx_sel = is_start ? a_cx : cx_reg;
    assign cy_sel = is_start ? a_cy : cy_reg;
    assign x_sel  = is_start ? '0 : w_x;
    assign y_sel  = is_start ? XW'(a_b) : w_y;

    assign rx_sum = SUMW'(cx_sel) + SUMW'(x_sel);
    assign lx_sum = SUMW'(cx_sel) - SUMW'(x_sel);
    assign uy_sum = SUMW'(cy_sel) + SUMW'(y_sel);
    assign ly_sum = SUMW'(cy_sel) - SUMW'(y_sel);

    always_comb
    begin
        active_next       = active_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        d_next            = d_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        aa_next           = aa_reg;
        bb_next           = bb_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        result_valid_next = result_valid_reg && result_stall;
        valid_res_next    = valid_res_reg;
        last_next         = last_reg;
        right_x_next      = right_x_reg;
        left_x_next       = left_x_reg;
        upper_y_next      = upper_y_reg;
        lower_y_next      = lower_y_reg;

        if (advance)
        begin
            result_valid_next = 1'b1;
            if (is_start)
            begin
                // Drop any ellipse in progress and load the new geometry
                x_next    = '0;
                y_next    = XW'(a_b);
                d_next    = d_start;
                px_next   = '0;
                py_next   = py_start;
                aa_next   = a_aa;
                bb_next   = a_bb;
                cx_next   = a_cx;
                cy_next   = a_cy;
                // With b = 0 the error term is a^2, never negative: y drops at once
                last_next = (a_b == '0);
            end
            else if (active_reg)
            begin
                x_next    = w_x;
                y_next    = w_y;
                d_next    = w_d;
                px_next   = w_px;
                py_next   = w_py;
                // At y = 0 the next move lowers y unless d < 0
                last_next = (w_y == '0) && !w_d[DW-1];
            end
            else
            begin
                last_next = 1'b0;
            end

            if (emit)
            begin
                active_next    = !last_next;
                valid_res_next = 1'b1;
                right_x_next   = $signed(rx_sum[OUTW-1:0]);
                left_x_next    = $signed(lx_sum[OUTW-1:0]);
                upper_y_next   = $signed(uy_sum[OUTW-1:0]);
                lower_y_next   = $signed(ly_sum[OUTW-1:0]);
            end
            else
            begin
                // Step with no ellipse in progress: empty point set
                valid_res_next = 1'b0;
                right_x_next   = '0;
                left_x_next    = '0;
                upper_y_next   = '0;
                lower_y_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg       <= active_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        d_reg         <= d_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        aa_reg        <= aa_next;
        bb_reg        <= bb_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        valid_res_reg <= valid_res_next;
        last_reg      <= last_next;
        right_x_reg   <= right_x_next;
        left_x_reg    <= left_x_next;
        upper_y_reg   <= upper_y_next;
        lower_y_reg   <= lower_y_next;
    end

    assign result_valid = result_valid_reg;
    assign valid_res    = valid_res_reg;
    assign last         = last_reg;
    assign right_x      = right_x_reg;
    assign left_x       = left_x_reg;
    assign upper_y      = upper_y_reg;
    assign lower_y      = lower_y_reg;

    property p_empty_set_is_zero;
        @(posedge clk) disable iff (!rst_n)
        result_valid && !valid_res |->
            right_x == '0 && left_x == '0 && upper_y == '0 && lower_y == '0 && !last;
    endproperty
    a_empty_set_is_zero: assert property (p_empty_set_is_zero)
        else $error("empty point set carries non-zero fields");

    property p_last_on_axis;
        @(posedge clk) disable iff (!rst_n)
        result_valid && last |-> upper_y == lower_y;
    endproperty
    a_last_on_axis: assert property (p_last_on_axis)
        else $error("final point set is not on the horizontal axis");

    property p_last_ends_walk;
        @(posedge clk) disable iff (!rst_n)
        advance && last_next |=> !active_reg;
    endproperty
    a_last_ends_walk: assert property (p_last_ends_walk)
        else $error("walk still active after its final point set");

    property p_start_arms_walk;
        @(posedge clk) disable iff (!rst_n)
        advance && is_start && (a_b != '0) |=> active_reg;
    endproperty
    a_start_arms_walk: assert property (p_start_arms_walk)
        else $error("start with a non-zero vertical semi-axis left the walk idle");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the ellipse rasteriser: point-set predictor, stimulus and checks.
`timescale 1ns / 1ps

module tb_top;
    import ebr_pkg::*;

    localparam int COORD_W     = 12;
    localparam int AXIS_W      = 11;
    localparam int OUT_W       = COORD_W + 2;
    localparam int RANDOM_END  = 475;     // directed transactions plus about 450 random ones
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    // One point set as the result channel carries it
    typedef struct packed
    {
        logic                    valid_res;
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] upper_y;
        logic signed [OUT_W-1:0] lower_y;
        logic                    last;
    } point_set_t;

    // Tracks the walk state of the block and holds the point sets still owed by it.
    class ellipse_walk_model;
        longint     col, row, ox, oy, err, asq, bsq;
        bit         walking;
        point_set_t pending_sets[$];
        int         failures;

        function new();
            col = 0;
            row = 0;
            ox = 0;
            oy = 0;
            err = 0;
            asq = 0;
            bsq = 0;
            walking = 1'b0;
            failures = 0;
        endfunction

        // One error-term move: horizontal, vertical or diagonal
        function void move(inout longint x, inout longint y, inout longint d);
            longint t;
            if (d < 0)
            begin
                t = 2 * d + 2 * asq * y - asq;
                x = x + 1;
                if (t < 0)
                    d = d + 2 * bsq * x + bsq;
                else
                begin
                    y = y - 1;
                    d = d + 2 * x * bsq - 2 * y * asq + asq + bsq;
                end
            end
            else if (d > 0)
            begin
                t = 2 * d - 2 * bsq * x - bsq;
                y = y - 1;
                if (t > 0)
                    d = d - 2 * y * asq + asq;
                else
                begin
                    x = x + 1;
                    d = d + 2 * x * bsq - 2 * y * asq + asq + bsq;
                end
            end
            else
            begin
                x = x + 1;
                y = y - 1;
                d = d + 2 * x * bsq - 2 * y * asq + asq + bsq;
            end
        endfunction

        // Four symmetric points of the current offsets; look one move ahead for the end
        function point_set_t next_point_set();
            point_set_t p;
            longint     nx, ny, nd;
            nx = ox;
            ny = oy;
            nd = err;
            move(nx, ny, nd);
            p.valid_res = 1'b1;
            p.right_x = OUT_W'(col + ox);
            p.left_x  = OUT_W'(col - ox);
            p.upper_y = OUT_W'(row + oy);
            p.lower_y = OUT_W'(row - oy);
            p.last    = (ny < 0);
            if (ny < 0)
                walking = 1'b0;
            return p;
        endfunction

        function void note_item(op_t kind, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                logic [AXIS_W-1:0] a, logic [AXIS_W-1:0] b);
            point_set_t p;
            longint     la, lb;
            la = longint'(a);
            lb = longint'(b);
            if (kind == OP_START)
            begin
                col = longint'(cx);
                row = longint'(cy);
                asq = la * la;
                bsq = lb * lb;
                ox = 0;
                oy = lb;
                err = asq + bsq - 2 * asq * lb;
                walking = 1'b1;
                p = next_point_set();
            end
            else if (!walking)
                p = '0;
            else
            begin
                move(ox, oy, err);
                p = next_point_set();
            end
            pending_sets.push_back(p);
        endfunction

        function void check_result(point_set_t got);
            point_set_t want;
            if (pending_sets.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("tb_top: unexpected point set valid_res=%0b right_x=%0d last=%0b",
                             got.valid_res, got.right_x, got.last);
                return;
            end
            want = pending_sets.pop_front();
            if (got.valid_res !== want.valid_res || got.right_x !== want.right_x ||
                got.left_x !== want.left_x || got.upper_y !== want.upper_y ||
                got.lower_y !== want.lower_y || got.last !== want.last)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                begin
                    $display("tb_top: mismatch expected v=%0b rx=%0d lx=%0d uy=%0d ly=%0d last=%0b",
                             want.valid_res, want.right_x, want.left_x, want.upper_y,
                             want.lower_y, want.last);
                    $display("tb_top:          actual   v=%0b rx=%0d lx=%0d uy=%0d ly=%0d last=%0b",
                             got.valid_res, got.right_x, got.left_x, got.upper_y,
                             got.lower_y, got.last);
                end
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_stall;
    logic                    op = 1'b0;
    logic [COORD_W-1:0]      center_x = '0;
    logic [COORD_W-1:0]      center_y = '0;
    logic [AXIS_W-1:0]       semi_axis_a = '0;
    logic [AXIS_W-1:0]       semi_axis_b = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic                    valid_res;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] upper_y;
    logic signed [OUT_W-1:0] lower_y;
    logic                    last;

    ellipse_walk_model walk = new();

    int gap_pct = 0;        // chance per cycle that the sender holds off
    int stall_pct = 0;      // chance per cycle that the receiver stalls
    int items_sent = 0;
    int cycle_count = 0;

    ellipse_bresenham_rasterizer #(
        .COORD_BITS (COORD_W),
        .AXIS_BITS  (AXIS_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .center_x     (center_x),
        .center_y     (center_y),
        .semi_axis_a  (semi_axis_a),
        .semi_axis_b  (semi_axis_b),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .valid_res    (valid_res),
        .right_x      (right_x),
        .left_x       (left_x),
        .upper_y      (upper_y),
        .lower_y      (lower_y),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one transaction, holding it until the block takes it, then note it for prediction.
    // Everything read just after the edge is the value from before the edge, since the block
    // and this bench both update on nonblocking assignments.
    task automatic send_item(input op_t kind, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [AXIS_W-1:0] a,
                             input logic [AXIS_W-1:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        op          <= kind;
        center_x    <= cx;
        center_y    <= cy;
        semi_axis_a <= a;
        semi_axis_b <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        walk.note_item(kind, cx, cy, a, b);
        items_sent++;
    endtask

    // Advance one step; the geometry fields are ignored by the block, so fill them with noise
    task automatic send_step();
        send_item(OP_STEP, COORD_W'($urandom), COORD_W'($urandom),
                  AXIS_W'($urandom), AXIS_W'($urandom));
    endtask

    // Step the ellipse in progress to its final point set, bounded, then step on while idle
    task automatic walk_out(input int cap, input int extra);
        int n;
        n = 0;
        while (walk.walking && n < cap)
        begin
            send_step();
            n++;
        end
        repeat (extra)
            send_step();
    endtask

    // Receive side: check every taken point set and stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                walk.check_result({valid_res, right_x, left_x, upper_y, lower_y, last});
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [AXIS_W-1:0] a;
        logic [AXIS_W-1:0] b;
        int                pick;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step with no ellipse, degenerate point, extremes of every field,
        // restart over a walk in progress, flat and thin ellipses walked to the end.
        send_step();
        send_item(OP_START, '0, '0, '0, '0);
        send_step();
        send_item(OP_START, '1, '1, '1, '1);
        repeat (3)
            send_step();
        send_item(OP_START, '0, '0, '1, '1);
        repeat (2)
            send_step();
        send_item(OP_START, COORD_W'(100), COORD_W'(100), AXIS_W'(0), AXIS_W'(3));
        walk_out(10, 0);
        send_item(OP_START, COORD_W'(2000), COORD_W'(50), AXIS_W'(4), AXIS_W'(0));
        walk_out(10, 1);
        send_item(OP_START, COORD_W'(7), COORD_W'(4000), AXIS_W'(5), AXIS_W'(3));
        walk_out(20, 1);

        // Random: mostly whole ellipses of small size, some cut short, some bare steps.
        // Idling changes in four phases as the run goes on.
        while (items_sent < RANDOM_END)
        begin
            case (items_sent * 4 / RANDOM_END)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 78;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 78;
                end
                default:
                begin
                    gap_pct = 12;
                    stall_pct = 12;
                end
            endcase
            if ($urandom_range(99) < 8)
                send_step();
            else
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                begin
                    a = AXIS_W'($urandom_range(12));
                    b = AXIS_W'($urandom_range(12));
                end
                else if (pick < 90)
                begin
                    a = AXIS_W'($urandom_range(30));
                    b = AXIS_W'($urandom_range(30));
                end
                else
                begin
                    a = AXIS_W'($urandom);
                    b = AXIS_W'($urandom);
                end
                send_item(OP_START, COORD_W'($urandom), COORD_W'($urandom), a, b);
                if ($urandom_range(99) < 10)
                    repeat ($urandom_range(5))
                        send_step();
                else
                    walk_out(80, $urandom_range(2));
            end
        end

        // Drain: stop offering, let the receiver run free and wait out the pipeline
        item_valid <= 1'b0;
        stall_pct = 0;
        while (walk.pending_sets.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (walk.failures == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[ellipse_bresenham_rasterizer.f]
hw/rtl/ebr_pkg.sv
hw/rtl/ebr_input_stage.sv
hw/rtl/ebr_walk.sv
hw/rtl/ellipse_bresenham_rasterizer.sv
tb/tb_top.sv
